@@ sv/baro_pkg.sv @@
`default_nettype none
package baro_pkg;

  typedef struct packed {
    logic        [15:0] t1;
    logic        [15:0] t2;
    logic signed [7:0]  t3;
    logic signed [15:0] p1;
    logic signed [15:0] p2;
    logic signed [7:0]  p3;
    logic signed [7:0]  p4;
    logic        [15:0] p5;
    logic        [15:0] p6;
    logic signed [7:0]  p7;
    logic signed [7:0]  p8;
    logic signed [15:0] p9;
    logic signed [7:0]  p10;
    logic signed [7:0]  p11;
  } calib_t;

  typedef enum logic [1:0] {
    REG_TEMP    = 2'd0,
    REG_PRESS_A = 2'd1,
    REG_PRESS_B = 2'd2,
    REG_PRESS_C = 2'd3
  } cfg_reg_t;

  typedef logic signed [28:0] tq_t;
  typedef logic signed [15:0] tout_t;

  localparam int unsigned CFG_W = 48;
  localparam logic signed [28:0] TQ_LIM = 29'sd134217728;
  localparam logic signed [60:0] TOUT_RND = 61'sd549755813888;
  localparam logic signed [60:0] TQ_RND = 61'sd134217728;
  localparam logic signed [51:0] PRESS_RND = 52'sd204800;
  localparam logic [27:0] PRESS_SAT = 28'd209715200;
  localparam logic [22:0] PRESS_MAX = 23'd8388607;
  localparam logic [28:0] DIV25_MUL = 29'd343597384;
  localparam int unsigned DIV25_SHIFT = 33;

endpackage
`default_nettype wire

@@ sv/baro_temp.sv @@
`default_nettype none
module baro_temp import baro_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [23:0] raw_p,
  input  wire logic [23:0] raw_t,
  input  wire calib_t      cal,
  output logic             out_valid,
  output logic [23:0]      u_o,
  output tout_t            tout_o,
  output tq_t              tq_o
);

  logic [3:0] v_r;
  logic signed [24:0] d_r;
  logic signed [41:0] m1_r;
  logic signed [49:0] dd_r;
  logic signed [60:0] tn_r;
  logic [23:0] u1_r, u2_r, u3_r, u4_r;
  tout_t tout_r;
  tq_t tq_r;

  logic signed [24:0] d_nxt;
  logic signed [57:0] ddt;
  logic signed [60:0] tn_nxt, tr, qr;
  logic signed [20:0] tsh;
  logic signed [32:0] qsh;
  tout_t tout_nxt;
  tq_t tq_nxt;

  always_comb begin
    d_nxt = $signed({1'b0, raw_t}) - $signed({1'b0, cal.t1, 8'h00});
    ddt = dd_r * cal.t3;
    tn_nxt = (61'(m1_r) <<< 18) + 61'(ddt);
    tr = tn_r + TOUT_RND;
    tsh = tr[60:40];
    if (tsh > 21'sd32767) begin
      tout_nxt = 16'sd32767;
    end else if (tsh < -21'sd32768) begin
      tout_nxt = -16'sd32768;
    end else begin
      tout_nxt = tsh[15:0];
    end
    qr = tn_r + TQ_RND;
    qsh = qr[60:28];
    if (qsh > 33'(TQ_LIM)) begin
      tq_nxt = TQ_LIM;
    end else if (qsh < -33'(TQ_LIM)) begin
      tq_nxt = -TQ_LIM;
    end else begin
      tq_nxt = qsh[28:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= d_nxt;
      u1_r   <= raw_p;
      m1_r   <= d_r * $signed({1'b0, cal.t2});
      dd_r   <= d_r * d_r;
      u2_r   <= u1_r;
      tn_r   <= tn_nxt;
      u3_r   <= u2_r;
      tout_r <= tout_nxt;
      tq_r   <= tq_nxt;
      u4_r   <= u3_r;
    end
  end

  assign out_valid = v_r[3];
  assign u_o = u4_r;
  assign tout_o = tout_r;
  assign tq_o = tq_r;

endmodule
`default_nettype wire

@@ sv/baro_poly.sv @@
`default_nettype none
module baro_poly import baro_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [23:0] u_i,
  input  wire tout_t       tout_i,
  input  wire tq_t         tq_i,
  input  wire calib_t      cal,
  output logic             out_valid,
  output tout_t            tout_o,
  output logic signed [48:0] o2_o,
  output logic signed [47:0] rest_o
);

  logic [4:0] v_r;
  tout_t t5_r, t6_r, t7_r, t8_r, t9_r;
  logic [23:0] u5_r, u6_r, u7_r, u8_r;

  logic signed [35:0] tq2_r;
  tq_t tq5_r;
  logic signed [45:0] a6_r, a2_r;
  logic signed [37:0] c_r;
  logic [47:0] u2_r;

  logic signed [42:0] tq3_r;
  logic signed [43:0] b7_r, b3_r;
  logic signed [62:0] hc_r;
  logic signed [38:0] lc_r;
  logic signed [39:0] q4_r;
  logic signed [47:0] o1a_r;
  logic signed [39:0] sa_r;

  logic signed [50:0] c8_r, c4_r;
  logic signed [47:0] o1b_r;
  logic signed [39:0] sb_r;
  logic signed [42:0] o3_r;
  logic signed [40:0] o4_r;

  logic signed [47:0] o1_r;
  logic signed [39:0] s_r;
  logic signed [42:0] o3b_r;
  logic signed [40:0] o4b_r;

  logic signed [48:0] o2_r;
  logic signed [47:0] rest_r;

  logic signed [57:0] tq2f;
  logic signed [36:0] p10t;
  logic signed [16:0] p2m, p1m;
  logic signed [64:0] t3f, o4f, o2f;
  logic signed [62:0] lcf, o3f;
  logic signed [56:0] q4f;
  logic signed [24:0] u6s, u8s;

  always_comb begin
    tq2f = tq_i * tq_i;
    p10t = cal.p10 * tq_i;
    p2m = 17'($signed(cal.p2)) - 17'sd16384;
    p1m = 17'($signed(cal.p1)) - 17'sd16384;
    t3f = tq2_r * tq5_r;
    lcf = $signed({1'b0, u2_r[23:0]}) * c_r;
    q4f = $signed({1'b0, u2_r}) * cal.p11;
    u6s = $signed({1'b0, u6_r});
    u8s = $signed({1'b0, u8_r});
    o3f = hc_r + 63'(lc_r);
    o4f = q4_r * u6s;
    o2f = s_r * u8s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t5_r  <= tout_i;
      u5_r  <= u_i;
      tq5_r <= tq_i;
      tq2_r <= 36'(tq2f >>> 20);
      a6_r  <= $signed({1'b0, cal.p6}) * tq_i;
      a2_r  <= p2m * tq_i;
      c_r   <= (38'($signed(cal.p9)) <<< 20) + 38'(p10t);
      u2_r  <= u_i * u_i;

      t6_r  <= t5_r;
      u6_r  <= u5_r;
      tq3_r <= 43'(t3f >>> 20);
      b7_r  <= cal.p7 * tq2_r;
      b3_r  <= cal.p3 * tq2_r;
      hc_r  <= $signed({1'b0, u2_r[47:24]}) * c_r;
      lc_r  <= 39'(lcf >>> 24);
      q4_r  <= 40'(q4f >>> 17);
      o1a_r <= (48'($signed({1'b0, cal.p5})) <<< 27) + 48'(a6_r >>> 2);
      sa_r  <= (40'(p1m) <<< 20) + 40'(a2_r >>> 9);

      t7_r  <= t6_r;
      u7_r  <= u6_r;
      c8_r  <= cal.p8 * tq3_r;
      c4_r  <= cal.p4 * tq3_r;
      o1b_r <= o1a_r + 48'(b7_r >>> 4);
      sb_r  <= sa_r + 40'(b3_r >>> 12);
      o3_r  <= 43'(o3f >>> 20);
      o4_r  <= 41'(o4f >>> 24);

      t8_r  <= t7_r;
      u8_r  <= u7_r;
      o1_r  <= o1b_r + 48'(c8_r >>> 11);
      s_r   <= sb_r + 40'(c4_r >>> 17);
      o3b_r <= o3_r;
      o4b_r <= o4_r;

      t9_r   <= t8_r;
      o2_r   <= 49'(o2f >>> 16);
      rest_r <= o1_r + 48'(o3b_r) + 48'(o4b_r);
    end
  end

  assign out_valid = v_r[4];
  assign tout_o = t9_r;
  assign o2_o = o2_r;
  assign rest_o = rest_r;

endmodule
`default_nettype wire

@@ sv/baro_scale.sv @@
`default_nettype none
module baro_scale import baro_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire tout_t              tout_i,
  input  wire logic signed [48:0] o2_i,
  input  wire logic signed [47:0] rest_i,
  output logic                    out_valid,
  output tout_t                   tout_o,
  output logic [22:0]             pout_o
);

  logic [1:0] v_r;
  tout_t t10_r, t11_r;
  logic [27:0] x_r;
  logic neg10_r, sat10_r, neg11_r, sat11_r;
  logic [56:0] prod_r;

  logic signed [51:0] p, pr;
  logic [37:0] y;

  always_comb begin
    p = 52'(o2_i) + 52'(rest_i);
    pr = p + PRESS_RND;
    y = pr[51:14];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t10_r   <= tout_i;
      neg10_r <= p[51];
      sat10_r <= (y >= 38'(PRESS_SAT));
      x_r     <= y[27:0];
      t11_r   <= t10_r;
      neg11_r <= neg10_r;
      sat11_r <= sat10_r;
      prod_r  <= x_r * DIV25_MUL;
    end
  end

  always_comb begin
    if (neg11_r) begin
      pout_o = '0;
    end else if (sat11_r) begin
      pout_o = PRESS_MAX;
    end else begin
      pout_o = prod_r[DIV25_SHIFT +: 23];
    end
  end

  assign out_valid = v_r[1];
  assign tout_o = t11_r;

endmodule
`default_nettype wire

@@ sv/baro_pressure_compensation_core.sv @@
// Channel  Dir  tdata bits (low first)                              Other
// in_      in   raw_pressure[23:0], raw_temperature[47:24]          tvalid, tready
// out_     out  temperature_out[15:0], pressure_out[38:16], 0[39]   tvalid, tready
// cfg_     in   cfg_wdata[47:0] to register cfg_addr                cfg_wr_en
// One beat is accepted per cycle unless a result waits on out_tready.
// The latency is set by the chain of multiplies through the temperature square and cube.
// Synchronous active-low reset empties the pipeline and clears the calibration registers.
// The whole pipeline holds while a result waits on out_tready; nothing is lost or repeated.
`default_nettype none
module baro_pressure_compensation_core import baro_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [47:0]      in_tdata,   // raw_pressure, raw_temperature
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [39:0]           out_tdata,  // temperature_out, pressure_out, zero pad
  input  wire logic             cfg_wr_en,
  input  wire logic [1:0]       cfg_addr,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  logic [39:0] temp_calib_r;
  logic [47:0] press_a_r, press_b_r;
  logic [31:0] press_c_r;
  calib_t cal;

  logic en;
  logic tv, pv, sv_v;
  logic [23:0] tu;
  tout_t ttout, ptout, stout;
  tq_t ttq;
  logic signed [48:0] po2;
  logic signed [47:0] prest;
  logic [22:0] spout;

  logic out_tvalid_r;
  logic [39:0] out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_calib_r <= '0;
      press_a_r    <= '0;
      press_b_r    <= '0;
      press_c_r    <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_addr))
        REG_TEMP:    temp_calib_r <= cfg_wdata[39:0];
        REG_PRESS_A: press_a_r    <= cfg_wdata[47:0];
        REG_PRESS_B: press_b_r    <= cfg_wdata[47:0];
        REG_PRESS_C: press_c_r    <= cfg_wdata[31:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    cal.t1  = temp_calib_r[15:0];
    cal.t2  = temp_calib_r[31:16];
    cal.t3  = temp_calib_r[39:32];
    cal.p1  = press_a_r[15:0];
    cal.p2  = press_a_r[31:16];
    cal.p3  = press_a_r[39:32];
    cal.p4  = press_a_r[47:40];
    cal.p5  = press_b_r[15:0];
    cal.p6  = press_b_r[31:16];
    cal.p7  = press_b_r[39:32];
    cal.p8  = press_b_r[47:40];
    cal.p9  = press_c_r[15:0];
    cal.p10 = press_c_r[23:16];
    cal.p11 = press_c_r[31:24];
  end

  assign en = !out_tvalid_r || out_tready;
  assign in_tready = en;

  baro_temp u_temp (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_tvalid),
    .raw_p(in_tdata[23:0]), .raw_t(in_tdata[47:24]), .cal(cal),
    .out_valid(tv), .u_o(tu), .tout_o(ttout), .tq_o(ttq)
  );

  baro_poly u_poly (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(tv),
    .u_i(tu), .tout_i(ttout), .tq_i(ttq), .cal(cal),
    .out_valid(pv), .tout_o(ptout), .o2_o(po2), .rest_o(prest)
  );

  baro_scale u_scale (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(pv),
    .tout_i(ptout), .o2_i(po2), .rest_i(prest),
    .out_valid(sv_v), .tout_o(stout), .pout_o(spout)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= sv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= {1'b0, spout, stout};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata = out_tdata_r;

endmodule
`default_nettype wire

@@ sv/baro_checker.sv @@
`default_nettype none
module baro_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata)) else $error("result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid) else $error("result after reset");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39] == 1'b0) else $error("pad bit set");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready) else $error("input blocked");

endmodule

bind baro_pressure_compensation_core baro_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
`default_nettype wire
